### hw/rtl/seeprom_pkg.sv
// ----------------------------------------------------------------------------
// seeprom_pkg
// Shared types and constants of the serial EEPROM storage core: request and
// result payloads, operation codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package seeprom_pkg;

	localparam logic [1:0] OP_MATCH = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [3:0] DEV_NIBBLE_RST = 4'd10;
	localparam logic [7:0] ERASED_BYTE    = 8'hFF;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] value;
		logic       first;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       matched;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic read_done;
		logic commit_step;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
		logic starts_commit;
		logic commit_end;
	} dp_sts_t;

endpackage

### hw/rtl/seeprom_ram.sv
// ----------------------------------------------------------------------------
// seeprom_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module seeprom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/seeprom_ctrl.sv
// ----------------------------------------------------------------------------
// seeprom_ctrl
// Controller: request acceptance, read wait, commit sequencing and the
// result valid flag.
// ----------------------------------------------------------------------------
module seeprom_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  seeprom_pkg::dp_sts_t sts,
	output seeprom_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   out_set;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_set  = (accept && !sts.is_read) || (state_q == ST_READ);

	assign cmd.accept      = accept;
	assign cmd.read_done   = (state_q == ST_READ);
	assign cmd.commit_step = (state_q == ST_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sts.is_read) begin
							state_q <= ST_READ;
						end else if (sts.starts_commit) begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_COMMIT: begin
					if (sts.commit_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/seeprom_dp.sv
// ----------------------------------------------------------------------------
// seeprom_dp
// Datapath: device nibble, address pointer, staging buffer, storage RAM with
// written flags, address match and the result register.
// ----------------------------------------------------------------------------
module seeprom_dp #(
	parameter int MEM_BYTES   = 128,
	parameter int BURST_LIMIT = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [3:0]             cfg_data,
	input  seeprom_pkg::in_item_t  in_data,
	output seeprom_pkg::out_item_t out_data,
	input  seeprom_pkg::dp_cmd_t   cmd,
	output seeprom_pkg::dp_sts_t   sts
);

	localparam int PTR_W  = $clog2(MEM_BYTES);
	localparam int HEAD_W = (BURST_LIMIT > 1) ? $clog2(BURST_LIMIT) : 1;
	localparam int CNT_W  = $clog2(BURST_LIMIT + 1);
	localparam int SUM_W  = CNT_W + 1;

	logic [3:0]             nibble_q;
	logic [PTR_W-1:0]       ptr_q;
	logic [PTR_W-1:0]       ptr_inc;
	logic [CNT_W-1:0]       count_q;
	logic [HEAD_W-1:0]      head_q;
	logic [HEAD_W-1:0]      head_inc;
	logic [SUM_W-1:0]       slot_sum;
	logic [HEAD_W-1:0]      tail_slot;
	logic [7:0]             stage_q [BURST_LIMIT];
	logic [MEM_BYTES-1:0]   written_q;
	logic                   rd_written_s1;
	logic [7:0]             ram_rdata;
	logic                   hit;
	seeprom_pkg::out_item_t out_q;
	logic [PTR_W-1:0]       ptr_of_value [256];

	for (genvar i = 0; i < 256; i++) begin : g_ptr_tbl
		assign ptr_of_value[i] = PTR_W'(i % MEM_BYTES);
	end

	assign ptr_inc  = (ptr_q == PTR_W'(MEM_BYTES - 1)) ? '0 : ptr_q + PTR_W'(1);
	assign head_inc = (head_q == HEAD_W'(BURST_LIMIT - 1)) ? '0 : head_q + HEAD_W'(1);
	assign slot_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_slot = (slot_sum >= SUM_W'(BURST_LIMIT)) ?
		HEAD_W'(slot_sum - SUM_W'(BURST_LIMIT)) : HEAD_W'(slot_sum);

	assign hit = (in_data.value[7:4] == nibble_q) || (in_data.value[7:1] == 7'd0);

	assign sts.is_read       = (in_data.operation == seeprom_pkg::OP_READ);
	assign sts.starts_commit = (in_data.operation == seeprom_pkg::OP_WRITE)
		&& !in_data.first && in_data.last;
	assign sts.commit_end    = (count_q == CNT_W'(1));

	assign out_data = out_q;

	seeprom_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.commit_step),
		.waddr(ptr_q),
		.wdata(stage_q[head_q]),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_q  <= seeprom_pkg::DEV_NIBBLE_RST;
			ptr_q     <= '0;
			count_q   <= '0;
			head_q    <= '0;
			written_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				nibble_q <= cfg_data;
			end
			if (cmd.accept) begin
				case (in_data.operation)
					seeprom_pkg::OP_WRITE: begin
						if (in_data.first) begin
							ptr_q   <= ptr_of_value[in_data.value];
							count_q <= '0;
							head_q  <= '0;
						end else if (count_q < CNT_W'(BURST_LIMIT)) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							head_q <= head_inc;
						end
					end
					seeprom_pkg::OP_READ: begin
						ptr_q <= ptr_inc;
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit_step) begin
				written_q[ptr_q] <= 1'b1;
				ptr_q            <= ptr_inc;
				count_q          <= count_q - CNT_W'(1);
				head_q           <= (count_q == CNT_W'(1)) ? '0 : head_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_written_s1 <= written_q[ptr_q];
			out_q.read_data <= 8'd0;
			out_q.matched   <= (in_data.operation == seeprom_pkg::OP_MATCH) && hit;
			if ((in_data.operation == seeprom_pkg::OP_WRITE) && !in_data.first) begin
				stage_q[tail_slot] <= in_data.value;
			end
		end
		if (cmd.read_done) begin
			out_q.read_data <= rd_written_s1 ? ram_rdata : seeprom_pkg::ERASED_BYTE;
			out_q.matched   <= 1'b0;
		end
	end

endmodule

### hw/rtl/serial_eeprom_storage_core.sv
// ----------------------------------------------------------------------------
// serial_eeprom_storage_core
// Byte-level serial EEPROM storage: address match, staged burst writes
// committed at the last byte, and reads that advance the address pointer.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   in_data  (operation, value, first, last)
//  out      out_valid / out_stall out_data (read_data, matched)
//  cfg      cfg_valid / cfg_ready cfg_data (device nibble)
//
//  Match and write results are registered on acceptance; a read then waits
//  in the read state for the registered RAM read. A write marked last without
//  first commits each staged byte (1 to BURST_LIMIT) via the single write port.
//  Reset marks every storage byte as erased (reads 0xFF until written); no
//  clearing pass is needed. A new request is taken while the previous result
//  is being delivered; a stalled result blocks the next request.
// ----------------------------------------------------------------------------
module serial_eeprom_storage_core #(
	parameter int MEM_BYTES   = 128,
	parameter int BURST_LIMIT = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  seeprom_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output seeprom_pkg::out_item_t out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [3:0]             cfg_data
);

	seeprom_pkg::dp_cmd_t cmd;
	seeprom_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	seeprom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	seeprom_dp #(
		.MEM_BYTES  (MEM_BYTES),
		.BURST_LIMIT(BURST_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
